// File: hw/rtl/tdg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdg_pkg
// shared constants, register indexes and types for the distance graph builder
// ----------------------------------------------------------------------------
package tdg_pkg;

    // sizing
    localparam int MAX_POINTS = 64;
    localparam int MAX_DIMS   = 8;
    localparam int COORD_BITS = 16;

    localparam int IDX_W   = $clog2(MAX_POINTS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int POS_W   = $clog2(MAX_DIMS);
    localparam int DIMS_W  = 4;
    localparam int ADDR_W  = IDX_W + POS_W;
    localparam int DEPTH   = MAX_POINTS * MAX_DIMS;
    localparam int DIFF_W  = COORD_BITS + 1;
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int SUM_W   = SQ_W + $clog2(MAX_DIMS + 1);
    localparam int RAD_W   = SUM_W + (SUM_W % 2);
    localparam int ROOT_W  = RAD_W / 2;
    localparam int DIST_W  = 18;
    localparam int THR_W   = 18;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIMS      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd1;

    // reset values
    localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd2;

    // write request into the point store
    typedef struct packed {
        logic                         en;
        logic [ADDR_W-1:0]            addr;
        logic signed [COORD_BITS-1:0] data;
    } tdg_wr_t;

    // handshake with the root unit
    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } tdg_root_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } tdg_root_rsp_t;

endpackage

// File: hw/rtl/tdg_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdg_store
// point coordinate memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module tdg_store
    import tdg_pkg::*;
(
    input  logic                         clk,
    input  tdg_wr_t                      wr,
    input  logic                         rd_en,
    input  logic [ADDR_W-1:0]            rd_addr,
    output logic signed [COORD_BITS-1:0] rd_data
);

    logic signed [COORD_BITS-1:0] mem [DEPTH];
    logic signed [COORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/tdg_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdg_sqrt
// floor square root, restoring digit recurrence, one root bit per cycle
// ----------------------------------------------------------------------------
module tdg_sqrt
    import tdg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  tdg_root_req_t req,
    output tdg_root_rsp_t rsp
);

    localparam int REM_W   = ROOT_W + 1;
    localparam int SHIFT_W = ROOT_W + 3;
    localparam int STEP_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]   x_reg,    x_next;
    logic [REM_W-1:0]   rem_reg,  rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [STEP_W-1:0]  cnt_reg,  cnt_next;
    logic               done_reg, done_next;

    logic [SHIFT_W-1:0] rem_shift;
    logic [SHIFT_W-1:0] trial;
    logic [SHIFT_W-1:0] diff;

    // next partial remainder and trial divisor
    assign rem_shift = {rem_reg, x_reg[RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign diff      = rem_shift - trial;

    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next    = req.radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = STEP_W'(ROOT_W);
        end
        else if (cnt_reg != '0)
        begin
            x_next   = {x_reg[RAD_W-3:0], 2'b00};
            cnt_next = cnt_reg - 1'b1;
            if (rem_shift >= trial)
            begin
                rem_next  = diff[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_shift[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            done_next = (cnt_reg == STEP_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

// File: hw/rtl/threshold_distance_graph_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// threshold_distance_graph_builder_core
// pairwise distance and threshold edge builder over a stored point set
// ----------------------------------------------------------------------------
// usage
//   command channel: one coordinate beat is taken at a rising edge with start
//   high and busy low; start_of_set on a beat drops the stored set so that
//   the beat opens point 0 of a new set. coordinates arrive point-major,
//   dims_in_use per point; up to 64 points are kept, later beats are dropped
//   until the next start_of_set
//   a beat that does not finish a point is taken and busy stays low. the
//   beat that finishes point n raises busy for n pairs; each pair is a
//   multiply-accumulate pass over the coordinates (one memory read per
//   cycle, multiplier and adder registered behind it) followed by a square
//   root in the root unit
//   result channel: result_valid is high for one cycle per pair, pairs in
//   rising older_index, last_of_run on the final pair; the receiver cannot
//   stall, every result beat is taken in the cycle it is shown
//   config port: cfg_write with cfg_index and cfg_data, to be written only
//   while idle; the block itself does not enforce this; no read-back
//   reset clears point count, coordinate slot and threshold, sets dims to
//   its reset value; point memory is not cleared and needs no clearing pass
// ----------------------------------------------------------------------------
module threshold_distance_graph_builder_core
    import tdg_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    // command channel
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] coordinate,
    input  logic                         start_of_set,
    // configuration port
    input  logic                         cfg_write,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    // result channel
    output logic                         result_valid,
    output logic [IDX_W-1:0]             older_index,
    output logic [IDX_W-1:0]             newer_index,
    output logic [DIST_W-1:0]            pair_distance,
    output logic                         is_edge,
    output logic                         last_of_run
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_ROOT = 2'd2;

    // configuration registers
    logic [DIMS_W-1:0] dims_reg;
    logic [THR_W-1:0]  thresh_reg;

    // control state
    logic [1:0]        state_reg,  state_next;
    logic [CNT_W-1:0]  stored_reg, stored_next;
    logic [POS_W-1:0]  pos_reg,    pos_next;
    logic [IDX_W-1:0]  older_reg,  older_next;
    logic [IDX_W-1:0]  newer_reg,  newer_next;
    logic [DIMS_W-1:0] d_reg,      d_next;
    logic              rd_v_reg,   rd_v_next;
    logic              mul_v_reg,  mul_v_next;
    logic              out_v_reg,  out_v_next;
    logic [SUM_W-1:0]  acc_reg,    acc_next;

    // datapath
    logic signed [COORD_BITS-1:0] cur_point_reg [MAX_DIMS];
    logic signed [COORD_BITS-1:0] newer_q_reg;
    logic [SQ_W-1:0]              prod_reg;
    logic [IDX_W-1:0]             out_older_reg;
    logic [IDX_W-1:0]             out_newer_reg;
    logic [DIST_W-1:0]            out_dist_reg;
    logic                         out_edge_reg;
    logic                         out_last_reg;

    // accept path
    logic              accept;
    logic [CNT_W-1:0]  eff_stored;
    logic [POS_W-1:0]  eff_pos;
    logic              full;
    logic              completes;
    logic [DIMS_W-1:0] act_dims;
    logic              issuing;
    logic              last_pair;

    logic signed [COORD_BITS-1:0] older_coord;
    logic signed [DIFF_W-1:0]     diff;
    logic signed [2*DIFF_W-1:0]   square;

    tdg_wr_t       wr;
    tdg_root_req_t root_req;
    tdg_root_rsp_t root_rsp;

    // dims of zero act as one, anything above the store width as the maximum
    always_comb
    begin
        if (dims_reg == '0)
        begin
            act_dims = DIMS_W'(1);
        end
        else if (dims_reg > DIMS_W'(MAX_DIMS))
        begin
            act_dims = DIMS_W'(MAX_DIMS);
        end
        else
        begin
            act_dims = dims_reg;
        end
    end

    assign busy       = (state_reg != S_IDLE);
    assign accept     = start && !busy;
    assign eff_stored = start_of_set ? '0 : stored_reg;
    assign eff_pos    = start_of_set ? '0 : pos_reg;
    assign full       = (eff_stored >= CNT_W'(MAX_POINTS));
    assign completes  = (({1'b0, eff_pos} + 1'b1) >= act_dims);

    // coordinate lands in the store and in the local copy of the open point
    assign wr.en   = accept && !full;
    assign wr.addr = {eff_stored[IDX_W-1:0], eff_pos};
    assign wr.data = coordinate;

    // one coordinate of the older point is read per cycle of the mac pass
    assign issuing   = (state_reg == S_MAC) && (d_reg < act_dims);
    assign last_pair = (({1'b0, older_reg} + 1'b1) == {1'b0, newer_reg});

    tdg_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd_en   (issuing),
        .rd_addr ({older_reg, d_reg[POS_W-1:0]}),
        .rd_data (older_coord)
    );

    // difference and square, registered before the accumulator
    assign diff   = DIFF_W'(newer_q_reg) - DIFF_W'(older_coord);
    assign square = diff * diff;

    assign root_req.start    = (state_reg == S_MAC) && !issuing && !rd_v_reg && !mul_v_reg;
    assign root_req.radicand = RAD_W'(acc_reg);

    tdg_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (root_req),
        .rsp   (root_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        stored_next = stored_reg;
        pos_next    = pos_reg;
        older_next  = older_reg;
        newer_next  = newer_reg;
        d_next      = d_reg;
        rd_v_next   = issuing;
        mul_v_next  = rd_v_reg;
        out_v_next  = 1'b0;
        acc_next    = acc_reg;

        if (mul_v_reg)
        begin
            acc_next = acc_reg + SUM_W'(prod_reg);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    stored_next = eff_stored;
                    pos_next    = eff_pos;
                    if (!full)
                    begin
                        if (!completes)
                        begin
                            pos_next = eff_pos + 1'b1;
                        end
                        else
                        begin
                            pos_next    = '0;
                            stored_next = eff_stored + 1'b1;
                            newer_next  = eff_stored[IDX_W-1:0];
                            older_next  = '0;
                            d_next      = '0;
                            acc_next    = '0;
                            // the first point of a set has nothing to pair with
                            if (eff_stored != '0)
                            begin
                                state_next = S_MAC;
                            end
                        end
                    end
                end
            end
            S_MAC:
            begin
                if (issuing)
                begin
                    d_next = d_reg + 1'b1;
                end
                else if (root_req.start)
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (root_rsp.done)
                begin
                    out_v_next = 1'b1;
                    if (last_pair)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        older_next = older_reg + 1'b1;
                        d_next     = '0;
                        acc_next   = '0;
                        state_next = S_MAC;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            stored_reg <= '0;
            pos_reg    <= '0;
            older_reg  <= '0;
            newer_reg  <= '0;
            d_reg      <= '0;
            rd_v_reg   <= 1'b0;
            mul_v_reg  <= 1'b0;
            out_v_reg  <= 1'b0;
            acc_reg    <= '0;
            dims_reg   <= DIMS_RESET;
            thresh_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            stored_reg <= stored_next;
            pos_reg    <= pos_next;
            older_reg  <= older_next;
            newer_reg  <= newer_next;
            d_reg      <= d_next;
            rd_v_reg   <= rd_v_next;
            mul_v_reg  <= mul_v_next;
            out_v_reg  <= out_v_next;
            acc_reg    <= acc_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DIMS:      dims_reg   <= cfg_data[DIMS_W-1:0];
                    REG_THRESHOLD: thresh_reg <= cfg_data[THR_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            cur_point_reg[eff_pos] <= coordinate;
        end
        if (issuing)
        begin
            newer_q_reg <= cur_point_reg[d_reg[POS_W-1:0]];
        end
        if (rd_v_reg)
        begin
            prod_reg <= square[SQ_W-1:0];
        end
        if (root_rsp.done)
        begin
            out_older_reg <= older_reg;
            out_newer_reg <= newer_reg;
            out_dist_reg  <= DIST_W'(root_rsp.root);
            out_edge_reg  <= (THR_W'(root_rsp.root) <= thresh_reg);
            out_last_reg  <= last_pair;
        end
    end

    assign result_valid  = out_v_reg;
    assign older_index   = out_older_reg;
    assign newer_index   = out_newer_reg;
    assign pair_distance = out_dist_reg;
    assign is_edge       = out_edge_reg;
    assign last_of_run   = out_last_reg;

endmodule

// File: hw/rtl/tdg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdg_checker
// port level checks on the result beats of the distance graph builder
// ----------------------------------------------------------------------------
module tdg_checker
    import tdg_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             busy,
    input logic             result_valid,
    input logic [IDX_W-1:0] older_index,
    input logic [IDX_W-1:0] newer_index,
    input logic             last_of_run
);

    // a run keeps the block busy until its final pair is shown
    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_run |-> busy)
        else $error("result beat inside a run without busy");

    // the final pair frees the command channel
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_run |-> !busy)
        else $error("busy still high on final pair");

    // the older point always precedes the newer one
    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (older_index < newer_index))
        else $error("older index not below newer index");

    // the final pair is the one just before the newer point
    a_last_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_run |-> (older_index + 1'b1 == newer_index))
        else $error("final pair not adjacent to newer point");

    // each pair needs a full root pass, so beats never come back to back
    a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result beats back to back");

endmodule

bind threshold_distance_graph_builder_core tdg_checker u_tdg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .busy         (busy),
    .result_valid (result_valid),
    .older_index  (older_index),
    .newer_index  (newer_index),
    .last_of_run  (last_of_run)
);

// File: tb/sv/tb_threshold_distance_graph_builder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_threshold_distance_graph_builder_core
// self-checking bench for the pairwise distance and threshold edge builder;
// coordinate beats go in through a queue-fed driver, a tracking model of the
// point set predicts every pair, and a monitor compares each result beat in
// order against the oldest predicted pair
// ----------------------------------------------------------------------------
module tb_threshold_distance_graph_builder_core;
    import tdg_pkg::*;

    localparam int STALL_LIMIT = 5000;  // cycles with no beat, result or write
    localparam int SETTLE_TAIL = 30;    // covers one pair at the widest dims
    localparam longint unsigned DIST_CAP = 262143;

    // one coordinate beat for the command channel
    typedef struct {
        logic signed [COORD_BITS-1:0] coord;
        logic                         sos;
    } coord_beat_t;

    // one predicted pair
    typedef struct {
        logic [IDX_W-1:0]  older;
        logic [IDX_W-1:0]  newer;
        logic [DIST_W-1:0] distance;
        logic              hit;
        logic              run_end;
    } pair_t;

    // dut ports; the inputs are driven from time zero
    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         start        = 1'b0;
    logic                         busy;
    logic signed [COORD_BITS-1:0] coordinate   = '0;
    logic                         start_of_set = 1'b0;
    logic                         cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index    = '0;
    logic [CFG_DATA_W-1:0]        cfg_data     = '0;
    logic                         result_valid;
    logic [IDX_W-1:0]             older_index;
    logic [IDX_W-1:0]             newer_index;
    logic [DIST_W-1:0]            pair_distance;
    logic                         is_edge;
    logic                         last_of_run;

    // stimulus bookkeeping
    coord_beat_t coord_beats[$];
    pair_t       expected_pairs[$];
    int          beats_queued = 0;
    int          beats_taken  = 0;
    int          errors       = 0;
    int          stall_cycles = 0;
    int          gap_left     = 0;
    bit          idle_on      = 1'b1;
    bit          took_beat    = 1'b0;

    // tracking copy of the block: point memory, fill count, slot, registers
    logic signed [COORD_BITS-1:0] pt_mem [MAX_POINTS][MAX_DIMS];
    int unsigned                  set_count  = 0;
    int unsigned                  coord_slot = 0;
    logic [DIMS_W-1:0]            dims_reg   = DIMS_RESET;
    logic [THR_W-1:0]             thr_reg    = '0;

    threshold_distance_graph_builder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .coordinate    (coordinate),
        .start_of_set  (start_of_set),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .older_index   (older_index),
        .newer_index   (newer_index),
        .pair_distance (pair_distance),
        .is_edge       (is_edge),
        .last_of_run   (last_of_run)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // dimension register as the block reads it: zero means one, above max clamps
    function automatic int unsigned dims_effective(logic [DIMS_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_DIMS)
            return MAX_DIMS;
        return v;
    endfunction

    // floor square root, one result bit per step from the top down
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = 20; b >= 0; b--)
        begin
            t = r | (longint'(1) << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // apply one accepted beat to the tracked point set and queue its pairs
    task automatic predict_pairs(logic signed [COORD_BITS-1:0] coord, logic sos);
        int unsigned     n_dims;
        int unsigned     newer;
        longint          diff;
        longint unsigned sum;
        longint unsigned root;
        pair_t           p;
        n_dims = dims_effective(dims_reg);
        if (sos)
        begin
            set_count  = 0;
            coord_slot = 0;
        end
        // store full: beat dropped until the next start of set
        if (set_count >= MAX_POINTS)
            return;
        if (coord_slot >= MAX_DIMS)
            coord_slot = MAX_DIMS - 1;
        pt_mem[set_count][coord_slot] = coord;
        // point not finished yet; also covers a dimension count shrunk mid-point
        if (coord_slot + 1 < n_dims)
        begin
            coord_slot++;
            return;
        end
        newer      = set_count;
        set_count  = set_count + 1;
        coord_slot = 0;
        for (int unsigned k = 0; k < newer; k++)
        begin
            sum = 0;
            for (int unsigned d = 0; d < n_dims; d++)
            begin
                diff = longint'(pt_mem[newer][d]) - longint'(pt_mem[k][d]);
                sum  = sum + longint'(diff * diff);
            end
            root       = floor_root(sum);
            p.older    = k[IDX_W-1:0];
            p.newer    = newer[IDX_W-1:0];
            p.distance = (root > DIST_CAP) ? DIST_CAP[DIST_W-1:0] : root[DIST_W-1:0];
            p.hit      = (root <= longint'(thr_reg));
            p.run_end  = (k + 1 == newer);
            expected_pairs = {expected_pairs, p};
        end
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // driver: new inputs at the falling edge, a beat held until it is taken
    always @(negedge clk)
    begin
        coord_beat_t nxt;
        if (rst_n)
        begin
            if (!start || took_beat)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    start    <= 1'b0;
                end
                else if (coord_beats.size() != 0 && idle_on && $urandom_range(0, 3) == 0)
                begin
                    // idle burst: start held low, gap_left drawn from 0 to 10
                    gap_left <= $urandom_range(0, 10);
                    start    <= 1'b0;
                end
                else if (coord_beats.size() != 0)
                begin
                    nxt           = coord_beats.pop_front();
                    start        <= 1'b1;
                    coordinate   <= nxt.coord;
                    start_of_set <= nxt.sos;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: results first, then the beat taken at this edge, then writes
    always @(posedge clk)
    begin
        pair_t want;
        bit    took;
        if (rst_n)
        begin
            took = start && !busy;
            if (result_valid)
            begin
                if (expected_pairs.size() == 0)
                begin
                    $display("%0t: result with nothing expected, older %0d newer %0d dist %0d",
                             $time, older_index, newer_index, pair_distance);
                    errors++;
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    check_field("older_index", want.older, older_index);
                    check_field("newer_index", want.newer, newer_index);
                    check_field("pair_distance", want.distance, pair_distance);
                    check_field("is_edge", want.hit, is_edge);
                    check_field("last_of_run", want.run_end, last_of_run);
                end
            end
            if (took)
            begin
                predict_pairs(coordinate, start_of_set);
                beats_taken++;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_DIMS:      dims_reg = cfg_data[DIMS_W-1:0];
                    REG_THRESHOLD: thr_reg  = cfg_data[THR_W-1:0];
                    default:       ;
                endcase
            end
            took_beat <= took;
            // watchdog on cycles where nothing moves
            if (took || result_valid || cfg_write)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("** threshold_distance_graph_builder_core: FAILED **");
                $finish;
            end
        end
    end

    task automatic queue_beat(logic signed [COORD_BITS-1:0] coord, logic sos);
        coord_beat_t b;
        b.coord = coord;
        b.sos   = sos;
        coord_beats = {coord_beats, b};
        beats_queued++;
    endtask

    // wait for every beat taken, every pair seen and busy low, then a tail
    task automatic settle_block(int tail);
        do
            @(negedge clk);
        while (beats_taken != beats_queued || expected_pairs.size() != 0 || busy);
        repeat (tail) @(negedge clk);
    endtask

    // one register write; the dims register gets junk in the unused upper bits
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        logic [31:0] junk;
        junk = $urandom;
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        if (idx == REG_DIMS)
            cfg_data <= {junk[CFG_DATA_W-1:DIMS_W], val[DIMS_W-1:0]};
        else
            cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // coordinate styles: full range, small cluster, extremes
    function automatic logic signed [COORD_BITS-1:0] pick_coord(int style);
        logic [31:0] r;
        r = $urandom;
        case (style)
            0: return r[COORD_BITS-1:0];
            1: return COORD_BITS'(int'($urandom_range(0, 200)) - 100);
            default:
                case (r[1:0])
                    2'd0: return 16'sh8000;
                    2'd1: return 16'sh7fff;
                    2'd2: return 16'sh0000;
                    default: return 16'shffff;
                endcase
        endcase
    endfunction

    // stimulus
    initial
    begin
        int          rand_beats;
        int unsigned cur_act;
        int unsigned new_act;
        int          style;
        int          npts;
        int          sel;
        bit          fresh;
        logic [3:0]  dims_val;
        logic [17:0] thr_val;

        rand_beats = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // reset registers: two dims, threshold zero
        // opposite corners, then two identical points (distance zero is an edge)
        queue_beat(16'sh8000, 1'b1);
        queue_beat(16'sh7fff, 1'b0);
        queue_beat(16'sh7fff, 1'b0);
        queue_beat(16'sh8000, 1'b0);
        queue_beat(16'sh0000, 1'b0);
        queue_beat(16'sh0000, 1'b0);
        queue_beat(16'sh0000, 1'b0);
        queue_beat(16'sh0000, 1'b0);
        // start of set in the middle of a point restarts at point zero
        queue_beat(16'sd5, 1'b0);
        queue_beat(16'sd7, 1'b1);
        queue_beat(-16'sd9, 1'b0);
        queue_beat(16'sh7fff, 1'b0);
        queue_beat(16'sh7fff, 1'b0);
        settle_block(SETTLE_TAIL);

        // dims zero behaves as one, widest threshold
        write_reg(REG_DIMS, 18'd0);
        write_reg(REG_THRESHOLD, 18'h3ffff);
        queue_beat(16'sd1, 1'b1);
        queue_beat(-16'sd1, 1'b0);
        queue_beat(16'sh7fff, 1'b0);
        queue_beat(16'sh8000, 1'b0);
        settle_block(SETTLE_TAIL);

        // distance exactly on the threshold, then dims shrunk mid-point
        write_reg(REG_DIMS, 18'd3);
        write_reg(REG_THRESHOLD, 18'd100);
        queue_beat(16'sd10, 1'b1);
        queue_beat(16'sd20, 1'b0);
        queue_beat(16'sd30, 1'b0);
        queue_beat(16'sd10, 1'b0);
        queue_beat(16'sd20, 1'b0);
        queue_beat(16'sd130, 1'b0);
        queue_beat(16'sd1, 1'b0);
        queue_beat(16'sd2, 1'b0);
        settle_block(SETTLE_TAIL);
        write_reg(REG_DIMS, 18'd1);
        queue_beat(16'sd3, 1'b0);
        settle_block(SETTLE_TAIL);
        cur_act = 1;

        // fill the store to capacity and push a few beats past it
        write_reg(REG_DIMS, 18'd1);
        write_reg(REG_THRESHOLD, 18'($urandom_range(0, 40000)));
        for (int i = 0; i < MAX_POINTS + 6; i++)
        begin
            queue_beat(pick_coord(i % 2), (i == 0));
            rand_beats++;
        end

        // random phases: fresh register values, whole points, some stray restarts
        while (rand_beats < 320)
        begin
            settle_block(SETTLE_TAIL);
            // no idling over the closing stretch
            if (rand_beats >= 260)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            sel = $urandom_range(0, 9);
            if (sel == 0)
                dims_val = 4'd0;
            else if (sel == 9)
                dims_val = 4'($urandom_range(9, 15));
            else
                dims_val = 4'(sel);
            new_act = dims_effective(dims_val);
            style   = $urandom_range(0, 2);
            case ($urandom_range(0, 5))
                0: thr_val = 18'd0;
                1: thr_val = 18'h3ffff;
                default:
                    if (style == 1)
                        thr_val = 18'($urandom_range(0, 300));
                    else
                        thr_val = 18'($urandom_range(0, 262143));
            endcase
            write_reg(REG_DIMS, {14'd0, dims_val});
            write_reg(REG_THRESHOLD, thr_val);
            // a wider point than the set was built with must open a new set
            fresh   = (new_act > cur_act) || ($urandom_range(0, 2) == 0);
            cur_act = new_act;
            npts    = $urandom_range(1, 10);
            for (int p = 0; p < npts; p++)
            begin
                for (int d = 0; d < int'(new_act); d++)
                begin
                    queue_beat(pick_coord(style),
                               (p == 0 && d == 0 && fresh) || ($urandom_range(0, 24) == 0));
                    rand_beats++;
                end
            end
        end

        settle_block(50);
        if (errors == 0)
            $display("** threshold_distance_graph_builder_core: PASSED **");
        else
            $display("** threshold_distance_graph_builder_core: FAILED **");
        $finish;
    end

endmodule
